[src/scl_pkg.sv]
// Shared types, constants and codes of the image scaler.
package scl_pkg;

  localparam int MAX_SRC_W_DEF  = 256;
  localparam int MAX_SRC_H_DEF  = 256;
  localparam int FIFO_DEPTH_DEF = 4;

  localparam int COORD_W    = 10;
  localparam int SRC_DIM_W  = 9;
  localparam int DIM_W      = 11;
  localparam int STEP_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int POS_W      = STEP_W + COORD_W;
  localparam int PIX_W      = POS_W - FRAC_W;   // covers any source size up to 4096
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 3 * COLOR_W;
  localparam int GX_W       = FRAC_W + 1;
  localparam int WGT_W      = 2 * FRAC_W + 1;
  localparam int ACC_W      = WGT_W + COLOR_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH     = 3'd6;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RST = 9'd256;
  localparam logic [DIM_W-1:0]     DST_DIM_RST = 11'd256;
  localparam logic [STEP_W-1:0]    STEP_RST    = 18'h10000;
  localparam logic                 SMOOTH_RST  = 1'b1;

  // Live settings as the front end sees them.
  typedef struct packed {
    logic [PIX_W-1:0]  lim_x;   // last usable source column
    logic [PIX_W-1:0]  lim_y;   // last usable source row
    logic [DIM_W-1:0]  dst_w;
    logic [DIM_W-1:0]  dst_h;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic              smooth;
  } cfg_t;

  // One classified transaction in the queue.
  typedef struct packed {
    logic               is_write;
    logic               skip;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [PIX_W-1:0]   x0;
    logic [PIX_W-1:0]   x1;
    logic [PIX_W-1:0]   y0;
    logic [PIX_W-1:0]   y1;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [RGB_W-1:0]   rgb;
  } op_t;

endpackage

[src/image_scaler_bilinear_nearest.sv]
// Top level of the RGB888 nearest/bilinear image scaler.
// Pipeline: a request passes the front register, the queue, the frame read and
//   the blend/output register; an output stall can hold it on the way.
// Throughput: one transaction per cycle while the output is not stalled, writes and
//   requests mixed; the four neighbors come from four parity banks, one read port each.
// Reset: control and settings reset at once; the frame store is not cleared.
module image_scaler_bilinear_nearest #(
  parameter int MAX_SOURCE_WIDTH  = scl_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SOURCE_HEIGHT = scl_pkg::MAX_SRC_H_DEF,
  parameter int FIFO_DEPTH        = scl_pkg::FIFO_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [scl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [scl_pkg::COORD_W-1:0]    coord_x_i,
  input  logic [scl_pkg::COORD_W-1:0]    coord_y_i,
  input  logic [scl_pkg::COLOR_W-1:0]    in_red_i,
  input  logic [scl_pkg::COLOR_W-1:0]    in_green_i,
  input  logic [scl_pkg::COLOR_W-1:0]    in_blue_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [scl_pkg::COLOR_W-1:0]    out_red_o,
  output logic [scl_pkg::COLOR_W-1:0]    out_green_o,
  output logic [scl_pkg::COLOR_W-1:0]    out_blue_o,
  output logic [scl_pkg::COORD_W-1:0]    dest_col_o,
  output logic [scl_pkg::COORD_W-1:0]    dest_row_o,
  output logic                           skipped_o
);
  import scl_pkg::*;

  // settings registers; the user must write them only while the pipe is empty (not enforced here)
  logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
  logic [DIM_W-1:0]     dst_w_q, dst_h_q;
  logic [STEP_W-1:0]    step_x_q, step_y_q;
  logic                 smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= SRC_DIM_RST;
      src_h_q  <= SRC_DIM_RST;
      dst_w_q  <= DST_DIM_RST;
      dst_h_q  <= DST_DIM_RST;
      step_x_q <= STEP_RST;
      step_y_q <= STEP_RST;
      smooth_q <= SMOOTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:  src_w_q  <= cfg_data_i[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_h_q  <= cfg_data_i[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_w_q  <= cfg_data_i[DIM_W-1:0];
        REG_DST_HEIGHT: dst_h_q  <= cfg_data_i[DIM_W-1:0];
        REG_STEP_X:     step_x_q <= cfg_data_i[STEP_W-1:0];
        REG_STEP_Y:     step_y_q <= cfg_data_i[STEP_W-1:0];
        REG_SMOOTH:     smooth_q <= cfg_data_i[0];
        default: ;      // unmapped index: write dropped
      endcase
    end
  end

  // Effective source size: zero acts as one, oversize clips to the store.
  cfg_t cfg;
  always_comb begin
    int ex, ey;
    ex = (src_w_q == '0) ? 1 :
         ((int'(src_w_q) > MAX_SOURCE_WIDTH) ? MAX_SOURCE_WIDTH : int'(src_w_q));
    ey = (src_h_q == '0) ? 1 :
         ((int'(src_h_q) > MAX_SOURCE_HEIGHT) ? MAX_SOURCE_HEIGHT : int'(src_h_q));
    cfg.lim_x  = PIX_W'(ex - 1);
    cfg.lim_y  = PIX_W'(ey - 1);
    cfg.dst_w  = dst_w_q;
    cfg.dst_h  = dst_h_q;
    cfg.step_x = step_x_q;
    cfg.step_y = step_y_q;
    cfg.smooth = smooth_q;
  end

  logic q_full, q_push, q_pop, q_empty;
  op_t  q_in, q_out;

  scl_front u_front (
    .clk_i,
    .rst_ni,
    .cfg_i      (cfg),
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .coord_x_i,
    .coord_y_i,
    .in_red_i,
    .in_green_i,
    .in_blue_i,
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  scl_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  scl_back #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_empty_i (q_empty),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .out_valid_o,
    .out_stall_i,
    .out_red_o,
    .out_green_o,
    .out_blue_o,
    .dest_col_o,
    .dest_row_o,
    .skipped_o
  );

endmodule

[src/scl_front.sv]
// Front end: accepts transactions, maps coordinates to source positions, filters.
module scl_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  scl_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        opcode_i,
  input  logic [scl_pkg::COORD_W-1:0] coord_x_i,
  input  logic [scl_pkg::COORD_W-1:0] coord_y_i,
  input  logic [scl_pkg::COLOR_W-1:0] in_red_i,
  input  logic [scl_pkg::COLOR_W-1:0] in_green_i,
  input  logic [scl_pkg::COLOR_W-1:0] in_blue_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output scl_pkg::op_t                q_data_o
);
  import scl_pkg::*;

  logic [POS_W-1:0] posx, posy;
  logic [PIX_W-1:0] ix, iy, x0, y0, x1, y1;
  logic             is_wr, keep, last_edge, smooth_live;
  logic             valid_d, valid_q;
  op_t              op_d, op_q;

  assign in_stall_o = valid_q && q_full_i;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = op_q;

  assign posx = POS_W'(cfg_i.step_x) * POS_W'(coord_x_i);
  assign posy = POS_W'(cfg_i.step_y) * POS_W'(coord_y_i);
  assign ix   = posx[POS_W-1:FRAC_W];
  assign iy   = posy[POS_W-1:FRAC_W];
  assign x0   = (ix > cfg_i.lim_x) ? cfg_i.lim_x : ix;
  assign y0   = (iy > cfg_i.lim_y) ? cfg_i.lim_y : iy;
  assign x1   = (x0 == cfg_i.lim_x) ? x0 : x0 + 1'b1;
  assign y1   = (y0 == cfg_i.lim_y) ? y0 : y0 + 1'b1;

  assign is_wr     = (opcode_i == OP_WRITE);
  assign last_edge = (DIM_W'(coord_x_i) == cfg_i.dst_w - 1'b1) ||
                     (DIM_W'(coord_y_i) == cfg_i.dst_h - 1'b1);
  assign smooth_live = cfg_i.smooth && !last_edge;

  always_comb begin
    if (is_wr) begin
      keep = (PIX_W'(coord_x_i) <= cfg_i.lim_x) && (PIX_W'(coord_y_i) <= cfg_i.lim_y);
    end else begin
      keep = (DIM_W'(coord_x_i) < cfg_i.dst_w) && (DIM_W'(coord_y_i) < cfg_i.dst_h);
    end
    op_d.is_write = is_wr;
    op_d.skip     = !is_wr && cfg_i.smooth && last_edge;
    op_d.cx       = coord_x_i;
    op_d.cy       = coord_y_i;
    op_d.rgb      = {in_red_i, in_green_i, in_blue_i};
    if (is_wr) begin
      op_d.x0 = PIX_W'(coord_x_i);
      op_d.y0 = PIX_W'(coord_y_i);
      op_d.x1 = PIX_W'(coord_x_i);
      op_d.y1 = PIX_W'(coord_y_i);
      op_d.fx = '0;
      op_d.fy = '0;
    end else if (smooth_live) begin
      op_d.x0 = x0;
      op_d.y0 = y0;
      op_d.x1 = x1;
      op_d.y1 = y1;
      op_d.fx = posx[FRAC_W-1:0];
      op_d.fy = posy[FRAC_W-1:0];
    end else begin
      // nearest: all weight on the floored pixel
      op_d.x0 = x0;
      op_d.y0 = y0;
      op_d.x1 = x0;
      op_d.y1 = y0;
      op_d.fx = '0;
      op_d.fy = '0;
    end
  end

  assign valid_d = in_valid_i && keep;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && valid_d) begin
      op_q <= op_d;
    end
  end

endmodule

[src/scl_fifo.sv]
// Short transaction queue between front and back end.
module scl_fifo #(
  parameter int DEPTH = scl_pkg::FIFO_DEPTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  scl_pkg::op_t data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output scl_pkg::op_t data_o
);
  import scl_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  op_t           slot_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue underflow");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && pop_i |=> $stable(cnt_q)) else $error("count moved on push and pop");

endmodule

[src/scl_back.sv]
// Back end: banked frame store, weight and blend pipeline, output register.
module scl_back #(
  parameter int MAX_SOURCE_WIDTH  = scl_pkg::MAX_SRC_W_DEF,
  parameter int MAX_SOURCE_HEIGHT = scl_pkg::MAX_SRC_H_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  scl_pkg::op_t                q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [scl_pkg::COLOR_W-1:0] out_red_o,
  output logic [scl_pkg::COLOR_W-1:0] out_green_o,
  output logic [scl_pkg::COLOR_W-1:0] out_blue_o,
  output logic [scl_pkg::COORD_W-1:0] dest_col_o,
  output logic [scl_pkg::COORD_W-1:0] dest_row_o,
  output logic                        skipped_o
);
  import scl_pkg::*;

  // Four banks by column and row parity: the 2x2 neighborhood hits each once.
  localparam int HALF_W = (MAX_SOURCE_WIDTH + 1) / 2;
  localparam int HALF_H = (MAX_SOURCE_HEIGHT + 1) / 2;
  localparam int DEPTH  = HALF_W * HALF_H;
  localparam int BA_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic adv, take;
  op_t  hd;

  assign adv     = !out_valid_o || !out_stall_i;
  assign take    = adv && !q_empty_i;
  assign q_pop_o = take;
  assign hd      = q_data_i;

  // stage 1
  logic                   v1_q, skip1_q;
  logic [COORD_W-1:0]     cx1_q, cy1_q;
  logic [1:0]             s00_q, s10_q, s01_q, s11_q;
  logic [WGT_W-1:0]       w00_q, w10_q, w01_q, w11_q;
  logic [3:0][RGB_W-1:0]  rd_q;
  logic [GX_W-1:0]        gx, gy, fxe, fye;

  assign fxe = GX_W'(hd.fx);
  assign fye = GX_W'(hd.fy);
  assign gx  = GX_W'(1 << FRAC_W) - fxe;
  assign gy  = GX_W'(1 << FRAC_W) - fye;

  function automatic logic [BA_W-1:0] bank_addr(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
    logic [31:0] a;
    a = 32'(row >> 1) * 32'(HALF_W) + 32'(col >> 1);
    return BA_W'(a);
  endfunction

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [RGB_W-1:0] mem_q [DEPTH];
    logic [PIX_W-1:0] rcol, rrow;
    logic [BA_W-1:0]  raddr, waddr;
    logic             wen;

    assign rcol  = (hd.x0[0] == b[0]) ? hd.x0 : hd.x1;
    assign rrow  = (hd.y0[0] == b[1]) ? hd.y0 : hd.y1;
    assign raddr = bank_addr(rcol, rrow);
    assign waddr = bank_addr(hd.x0, hd.y0);
    assign wen   = take && hd.is_write && ({hd.y0[0], hd.x0[0]} == 2'(b));

    always_ff @(posedge clk_i) begin
      if (wen) begin
        mem_q[waddr] <= hd.rgb;
      end
      if (adv) begin
        rd_q[b] <= mem_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= take && !hd.is_write;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      skip1_q <= hd.skip;
      cx1_q   <= hd.cx;
      cy1_q   <= hd.cy;
      s00_q   <= {hd.y0[0], hd.x0[0]};
      s10_q   <= {hd.y0[0], hd.x1[0]};
      s01_q   <= {hd.y1[0], hd.x0[0]};
      s11_q   <= {hd.y1[0], hd.x1[0]};
      w00_q   <= WGT_W'(gx) * WGT_W'(gy);
      w10_q   <= WGT_W'(fxe) * WGT_W'(gy);
      w01_q   <= WGT_W'(gx) * WGT_W'(fye);
      w11_q   <= WGT_W'(fxe) * WGT_W'(fye);
    end
  end

  // stage 2: blend, output register
  logic [RGB_W-1:0]   p00, p10, p01, p11;
  logic [RGB_W-1:0]   rgb_d;
  logic [ACC_W-1:0]   acc [3];
  logic               v2_q;
  logic [RGB_W-1:0]   rgb_q;
  logic [COORD_W-1:0] cx2_q, cy2_q;
  logic               skip2_q;

  assign p00 = rd_q[s00_q];
  assign p10 = rd_q[s10_q];
  assign p01 = rd_q[s01_q];
  assign p11 = rd_q[s11_q];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      acc[c] = ACC_W'(w00_q) * ACC_W'(p00[c*COLOR_W +: COLOR_W])
             + ACC_W'(w10_q) * ACC_W'(p10[c*COLOR_W +: COLOR_W])
             + ACC_W'(w01_q) * ACC_W'(p01[c*COLOR_W +: COLOR_W])
             + ACC_W'(w11_q) * ACC_W'(p11[c*COLOR_W +: COLOR_W]);
      rgb_d[c*COLOR_W +: COLOR_W] = skip1_q ? '0 : acc[c][ACC_W-1 -: COLOR_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rgb_q   <= rgb_d;
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      skip2_q <= skip1_q;
    end
  end

  assign out_valid_o = v2_q;
  assign out_red_o   = rgb_q[2*COLOR_W +: COLOR_W];
  assign out_green_o = rgb_q[COLOR_W +: COLOR_W];
  assign out_blue_o  = rgb_q[0 +: COLOR_W];
  assign dest_col_o  = cx2_q;
  assign dest_row_o  = cy2_q;
  assign skipped_o   = skip2_q;

  a_skip_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && skipped_o |-> rgb_q == '0) else $error("skipped result not black");
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && hd.is_write |=> !v1_q) else $error("pixel write produced a result");
  a_hold_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(v1_q) && (!v1_q || $stable(cx1_q)) &&
    !$past(q_pop_o))
    else $error("pipeline moved under stall");

endmodule

[tb/sv/image_scaler_bilinear_nearest_tb.sv]
// Self-checking testbench for the RGB888 nearest/bilinear image scaler.
module image_scaler_bilinear_nearest_tb;
  import scl_pkg::*;

  localparam int SRC_MAX   = 256;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 8;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               skip;
  } pixel_res_t;

  // Directed rows: op, coordinates, colour; has_exp marks rows with a typed answer.
  typedef struct {
    logic               op;
    int                 x;
    int                 y;
    logic [RGB_W-1:0]   rgb;
    bit                 has_exp;
    pixel_res_t         exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = 1'b0;
  logic [COORD_W-1:0] coord_x_i = '0;
  logic [COORD_W-1:0] coord_y_i = '0;
  logic [COLOR_W-1:0] in_red_i = '0;
  logic [COLOR_W-1:0] in_green_i = '0;
  logic [COLOR_W-1:0] in_blue_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [COLOR_W-1:0] out_red_o, out_green_o, out_blue_o;
  logic [COORD_W-1:0] dest_col_o, dest_row_o;
  logic skipped_o;

  image_scaler_bilinear_nearest dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Scaler state as the predictor sees it.
  logic [RGB_W-1:0] frame_mem [SRC_MAX*SRC_MAX];
  bit               frame_written [SRC_MAX*SRC_MAX];
  int unsigned src_w = 256, src_h = 256, dst_w = 256, dst_h = 256;
  int unsigned stp_x = 65536, stp_y = 65536;
  bit          smooth = 1'b1;

  pixel_res_t pending_pixels[$];
  int  errors = 0;
  int  idle_pct_in = 0, stall_pct_out = 0;
  int  wdog = 0;
  bit  direct_has_exp;
  pixel_res_t direct_exp;

  function automatic int unsigned eff_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > SRC_MAX) return SRC_MAX;
    return v;
  endfunction

  // Predicts the pixel for a request; returns 0 when no result comes out.
  function automatic bit scale_pixel(int unsigned cx, int unsigned cy, output pixel_res_t r);
    longint unsigned px, py, ix, iy, fx, fy, gx, gy, acc;
    longint unsigned w [4];
    int unsigned sw, sh, x0, y0, x1, y1;
    logic [RGB_W-1:0] p [4];
    sw = eff_dim(src_w);
    sh = eff_dim(src_h);
    r = '0;
    r.col = COORD_W'(cx);
    r.row = COORD_W'(cy);
    if (cx >= dst_w || cy >= dst_h) return 0;
    px = longint'(stp_x) * cx;
    py = longint'(stp_y) * cy;
    ix = px >> 16; iy = py >> 16;
    fx = px & 16'hFFFF; fy = py & 16'hFFFF;
    x0 = 32'((ix > sw - 1) ? sw - 1 : ix);
    y0 = 32'((iy > sh - 1) ? sh - 1 : iy);
    if (!smooth) begin
      {r.red, r.green, r.blue} = frame_mem[y0*SRC_MAX + x0];
      return 1;
    end
    if (cx == dst_w - 1 || cy == dst_h - 1) begin
      r.skip = 1'b1;
      return 1;
    end
    x1 = (x0 + 1 > sw - 1) ? sw - 1 : x0 + 1;
    y1 = (y0 + 1 > sh - 1) ? sh - 1 : y0 + 1;
    p[0] = frame_mem[y0*SRC_MAX + x0];
    p[1] = frame_mem[y0*SRC_MAX + x1];
    p[2] = frame_mem[y1*SRC_MAX + x0];
    p[3] = frame_mem[y1*SRC_MAX + x1];
    gx = 65536 - fx; gy = 65536 - fy;
    w[0] = gx*gy; w[1] = fx*gy; w[2] = gx*fy; w[3] = fx*fy;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int k = 0; k < 4; k++) acc += w[k] * ((p[k] >> (16 - 8*c)) & 8'hFF);
      case (c)
        0: r.red = COLOR_W'(acc >> 32);
        1: r.green = COLOR_W'(acc >> 32);
        default: r.blue = COLOR_W'(acc >> 32);
      endcase
    end
    return 1;
  endfunction

  // Model side of one accepted transaction.
  task automatic model_accept(logic op, int unsigned x, int unsigned y, logic [RGB_W-1:0] rgb);
    pixel_res_t r;
    if (op == OP_WRITE) begin
      if (x < eff_dim(src_w) && y < eff_dim(src_h)) begin
        frame_mem[y*SRC_MAX + x] = rgb;
        frame_written[y*SRC_MAX + x] = 1'b1;
      end
    end else if (scale_pixel(x, y, r)) begin
      if (direct_has_exp && r != direct_exp) begin
        $error("directed row: expected %h predicted %h", direct_exp, r);
        errors++;
      end
      pending_pixels.push_back(direct_has_exp ? direct_exp : r);
    end
  endtask

  // Whether all source pixels this request may touch have been written.
  function automatic bit reads_defined(int unsigned cx, int unsigned cy);
    int unsigned sw, sh, x0, y0, x1, y1;
    longint unsigned ix, iy;
    if (cx >= dst_w || cy >= dst_h) return 1;
    if (smooth && (cx == dst_w - 1 || cy == dst_h - 1)) return 1;
    sw = eff_dim(src_w); sh = eff_dim(src_h);
    ix = (longint'(stp_x) * cx) >> 16;
    iy = (longint'(stp_y) * cy) >> 16;
    x0 = 32'((ix > sw - 1) ? sw - 1 : ix);
    y0 = 32'((iy > sh - 1) ? sh - 1 : iy);
    x1 = (x0 + 1 > sw - 1) ? sw - 1 : x0 + 1;
    y1 = (y0 + 1 > sh - 1) ? sh - 1 : y0 + 1;
    return frame_written[y0*SRC_MAX+x0] && frame_written[y0*SRC_MAX+x1] &&
           frame_written[y1*SRC_MAX+x0] && frame_written[y1*SRC_MAX+x1];
  endfunction

  // Sends one transaction and waits for its acceptance; idles at random first.
  // Valid stays up afterwards; the next transaction or drain() takes it down.
  task automatic send_item(logic op, int unsigned x, int unsigned y, logic [RGB_W-1:0] rgb);
    while ($urandom_range(99) < idle_pct_in) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    coord_x_i   <= COORD_W'(x);
    coord_y_i   <= COORD_W'(y);
    {in_red_i, in_green_i, in_blue_i} <= rgb;
    do @(posedge clk_i); while (in_stall_o);
    model_accept(op, x, y, rgb);
  endtask

  // Waits until every expected pixel is out and the pipe has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    @(posedge clk_i);
    case (idx)
      REG_SRC_WIDTH:  src_w = val & 9'h1FF;
      REG_SRC_HEIGHT: src_h = val & 9'h1FF;
      REG_DST_WIDTH:  dst_w = val & 11'h7FF;
      REG_DST_HEIGHT: dst_h = val & 11'h7FF;
      REG_STEP_X:     stp_x = val & 18'h3FFFF;
      REG_STEP_Y:     stp_y = val & 18'h3FFFF;
      default:        smooth = val & 1;
    endcase
  endtask

  task automatic set_all(int unsigned sw, sh, dw, dh, sx, sy, bit sm);
    write_reg(REG_SRC_WIDTH, sw);
    write_reg(REG_SRC_HEIGHT, sh);
    write_reg(REG_DST_WIDTH, dw);
    write_reg(REG_DST_HEIGHT, dh);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_SMOOTH, sm);
    cfg_we_i <= 1'b0;
  endtask

  // Result checker: compares each accepted pixel with the oldest expectation.
  always @(posedge clk_i) begin
    pixel_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result at col %0d row %0d", dest_col_o, dest_row_o);
        errors++;
      end else begin
        e = pending_pixels.pop_front();
        if (out_red_o !== e.red) begin
          $error("out_red expected %0d actual %0d", e.red, out_red_o); errors++;
        end
        if (out_green_o !== e.green) begin
          $error("out_green expected %0d actual %0d", e.green, out_green_o); errors++;
        end
        if (out_blue_o !== e.blue) begin
          $error("out_blue expected %0d actual %0d", e.blue, out_blue_o); errors++;
        end
        if (dest_col_o !== e.col) begin
          $error("dest_col expected %0d actual %0d", e.col, dest_col_o); errors++;
        end
        if (dest_row_o !== e.row) begin
          $error("dest_row expected %0d actual %0d", e.row, dest_row_o); errors++;
        end
        if (skipped_o !== e.skip) begin
          $error("skipped expected %0d actual %0d", e.skip, skipped_o); errors++;
        end
      end
    end
  end

  // Receiver stall pattern.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct_out);
  end

  // Watchdog: cycles without any accepted transaction, delivered result or settings write.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog > WDOG_MAX) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Fills a small source frame completely with random colour.
  task automatic fill_frame(int unsigned w, int unsigned h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++) send_item(OP_WRITE, x, y, RGB_W'($urandom()));
  endtask

  task automatic random_phase(int n);
    int unsigned x, y;
    logic op;
    for (int i = 0; i < n; i++) begin
      op = ($urandom_range(3) != 0);
      if (op == OP_WRITE) begin
        // mostly in-frame, sometimes anywhere in the coordinate range
        x = $urandom_range(3) ? $urandom_range(eff_dim(src_w) - 1) : $urandom_range(1023);
        y = $urandom_range(3) ? $urandom_range(eff_dim(src_h) - 1) : $urandom_range(1023);
      end else begin
        x = $urandom_range(7) ? $urandom_range(dst_w - 1) : $urandom_range(1023);
        y = $urandom_range(7) ? $urandom_range(dst_h - 1) : $urandom_range(1023);
        if (!reads_defined(x, y)) continue;
      end
      send_item(op, x, y, RGB_W'($urandom()));
    end
  endtask

  stim_row_t dir_rows[$];

  function automatic stim_row_t row(logic op, int x, int y, logic [RGB_W-1:0] rgb, bit he,
                                    pixel_res_t e);
    stim_row_t s;
    s.op = op; s.x = x; s.y = y; s.rgb = rgb; s.has_exp = he; s.exp = e;
    return s;
  endfunction

  initial begin
    int phase_w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: 4x4 source, 8x8 destination, step 0.5.
    set_all(4, 4, 8, 8, 32768, 32768, 1'b1);
    fill_frame(4, 4);
    dir_rows.push_back(row(OP_WRITE, 0, 0, 24'hFFFFFF, 0, '0));
    dir_rows.push_back(row(OP_WRITE, 3, 3, 24'h000000, 0, '0));
    dir_rows.push_back(row(OP_WRITE, 4, 0, 24'h123456, 0, '0));       // outside frame
    dir_rows.push_back(row(OP_WRITE, 1023, 1023, 24'hABCDEF, 0, '0)); // outside frame
    dir_rows.push_back(row(OP_COMPUTE, 0, 0, '0, 1, '{8'hFF, 8'hFF, 8'hFF, 10'd0, 10'd0, 1'b0}));
    dir_rows.push_back(row(OP_COMPUTE, 7, 3, '0, 1, '{8'd0, 8'd0, 8'd0, 10'd7, 10'd3, 1'b1}));
    dir_rows.push_back(row(OP_COMPUTE, 2, 7, '0, 1, '{8'd0, 8'd0, 8'd0, 10'd2, 10'd7, 1'b1}));
    dir_rows.push_back(row(OP_COMPUTE, 8, 0, '0, 0, '0));             // no result
    dir_rows.push_back(row(OP_COMPUTE, 1023, 1023, '0, 0, '0));       // no result
    dir_rows.push_back(row(OP_COMPUTE, 1, 1, '0, 0, '0));
    dir_rows.push_back(row(OP_COMPUTE, 6, 6, '0, 0, '0));
    dir_rows.push_back(row(OP_COMPUTE, 5, 2, '0, 0, '0));
    foreach (dir_rows[i]) begin
      direct_has_exp = dir_rows[i].has_exp;
      direct_exp = dir_rows[i].exp;
      send_item(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].rgb);
    end
    direct_has_exp = 0;
    drain();

    // Edge clamp, zero step, odd sizes, nearest mode, then a small bilinear case.
    set_all(0, 300, 1024, 1024, 131072, 0, 1'b0);
    fill_frame(1, 2);
    send_item(OP_WRITE, 0, 255, RGB_W'($urandom()));
    send_item(OP_COMPUTE, 1023, 1023, '0);
    send_item(OP_COMPUTE, 0, 1023, '0);
    drain();
    set_all(4, 4, 2, 2, 1, 131072, 1'b1);
    send_item(OP_COMPUTE, 0, 0, '0);
    send_item(OP_COMPUTE, 1, 0, '0);
    drain();

    // Random phases over several settings and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct_in = 0;  stall_pct_out = 0;  end
        1: begin idle_pct_in = 73; stall_pct_out = 0;  end
        2: begin idle_pct_in = 0;  stall_pct_out = 73; end
        default: begin idle_pct_in = 29; stall_pct_out = 29; end
      endcase
      phase_w = $urandom_range(2, 8);
      set_all(phase_w, $urandom_range(2, 8), $urandom_range(2, 20), $urandom_range(2, 20),
              (ph == 7) ? 131072 : $urandom_range(1, 131072),
              (ph == 6) ? 1 : $urandom_range(0, 131072), ph[0]);
      fill_frame(eff_dim(src_w), eff_dim(src_h));
      random_phase(60);
      drain();
    end
    idle_pct_in = 0;
    stall_pct_out = 0;
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[image_scaler_bilinear_nearest.f]
src/scl_pkg.sv
src/scl_front.sv
src/scl_fifo.sv
src/scl_back.sv
src/image_scaler_bilinear_nearest.sv
tb/sv/image_scaler_bilinear_nearest_tb.sv
